>>> design/cr_vlf_pkg.sv
// Shared types and constants of the vector Laplacian face triplet generator.
package cr_vlf_pkg;

    localparam int unsigned ID_W    = 20;
    localparam int unsigned IDX_W   = 21;
    localparam int unsigned LEN_W   = 32;
    localparam int unsigned VAL_W   = 48;
    localparam int unsigned NUM_W   = 106;
    localparam int unsigned DEN_W   = 96;
    localparam int unsigned QUO_W   = 49;
    localparam int unsigned MAG_W   = 49;
    localparam int unsigned TM_W    = 33;
    localparam int unsigned TSQ_W   = 66;
    localparam int unsigned PROD_W  = 64;

    localparam logic [IDX_W-1:0] MAX_EDGES   = 21'd1048576;
    localparam logic [IDX_W-1:0] EDGES_RESET = 21'd1;
    localparam logic [MAG_W-1:0] MAG_CAP     = 49'h1_0000_0000_0000;

    // One corner of a face, ready for the divider and the emitter
    typedef struct packed {
        logic [ID_W-1:0]   ri;
        logic [ID_W-1:0]   rk;
        logic              oneg;
        logic              pneg;
        logic              last;
        logic [LEN_W-1:0]  area;
        logic [TM_W-1:0]   tm;
        logic [TSQ_W-1:0]  tsq;
        logic [PROD_W-1:0] prod;
        logic [DEN_W-1:0]  dden;
    } t_job;

endpackage

>>> design/cr_vector_laplacian_face_triplets.sv
// Top level of the Crouzeix-Raviart vector Laplacian face triplet generator.
//
// Slave stream (i_s_*) takes one face per transfer; master stream (o_m_*)
// gives thirty (row, col, value) triplets per face, tlast on the thirtieth.
// Config channel (i_cfg_*) writes edge_count, the row/column offset of the
// second vector component; values above 2^20 are clamped, reset value 1.
// Write it only while no face is in flight.
// A face is taken when the front end is free: each corner builds its
// products (|t|, its square and the edge product, then the low and high
// halves of the edge product times the area) and pushes its job, so with
// room in the queue the next face can enter once the third corner is
// pushed; in steady state the back end sets the pace. The back end shares
// one bit-serial divider, three divisions per corner, each as start, 49
// quotient bits, rounding and done; a pop and ten emits complete a corner.
// A zero divisor or a quotient of 2^49 or more is capped at once.
// A two-entry queue of corner jobs parts the front end from the back end;
// a stalled receiver holds the output register and backs up into the
// queue and then the slave side. Reset is synchronous and empties all.
module cr_vector_laplacian_face_triplets (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [20:0]  i_cfg_data,       // edge_count
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // sq_len_0, sq_len_1, sq_len_2, double_area, edge_id_0, edge_id_1,
    // edge_id_2, flip_0, flip_1, flip_2, zero fill
    input  logic [191:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [95:0]  o_m_tdata,        // row, col, value, zero fill
    output logic         o_m_tuser,        // saturated
    output logic         o_m_tlast
);

    logic [20:0]      r_edge_count;
    logic             q_full, q_empty, push, pop;
    cr_vlf_pkg::t_job push_job, head_job;

    // Clamp and hold edge_count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_count <= cr_vlf_pkg::EDGES_RESET;
        end else if (i_cfg_valid) begin
            r_edge_count <= (i_cfg_data > cr_vlf_pkg::MAX_EDGES) ? cr_vlf_pkg::MAX_EDGES
                                                                : i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    cr_vlf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_face_valid  (i_s_tvalid),
        .o_face_ready  (o_s_tready),
        .i_sq_len_0    (i_s_tdata[31:0]),
        .i_sq_len_1    (i_s_tdata[63:32]),
        .i_sq_len_2    (i_s_tdata[95:64]),
        .i_double_area (i_s_tdata[127:96]),
        .i_edge_id_0   (i_s_tdata[147:128]),
        .i_edge_id_1   (i_s_tdata[167:148]),
        .i_edge_id_2   (i_s_tdata[187:168]),
        .i_flip_0      (i_s_tdata[188]),
        .i_flip_1      (i_s_tdata[189]),
        .i_flip_2      (i_s_tdata[190]),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_job         (push_job)
    );

    cr_vlf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    cr_vlf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_edge_count (r_edge_count),
        .i_q_empty    (q_empty),
        .i_job        (head_job),
        .o_pop        (pop),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser),
        .o_m_tlast    (o_m_tlast)
    );

endmodule

>>> design/cr_vlf_front.sv
// Front end: accepts a face and builds one divider job per corner.
module cr_vlf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_face_valid,
    output logic              o_face_ready,
    input  logic [31:0]       i_sq_len_0,
    input  logic [31:0]       i_sq_len_1,
    input  logic [31:0]       i_sq_len_2,
    input  logic [31:0]       i_double_area,
    input  logic [19:0]       i_edge_id_0,
    input  logic [19:0]       i_edge_id_1,
    input  logic [19:0]       i_edge_id_2,
    input  logic              i_flip_0,
    input  logic              i_flip_1,
    input  logic              i_flip_2,
    input  logic              i_q_full,
    output logic              o_push,
    output cr_vlf_pkg::t_job  o_job
);

    logic                         r_busy, n_busy;
    logic [1:0]                   r_corner, n_corner;
    logic [1:0]                   r_phase, n_phase;
    logic [31:0]                  r_len0, r_len1, r_len2, r_area;
    logic [19:0]                  r_id0, r_id1, r_id2;
    logic                         r_fl0, r_fl1, r_fl2;
    logic [cr_vlf_pkg::TM_W-1:0]   r_tm;
    logic [cr_vlf_pkg::TSQ_W-1:0]  r_tsq;
    logic [cr_vlf_pkg::PROD_W-1:0] r_prod;
    logic [63:0]                  r_plo, r_phi;
    logic [19:0]                  r_ri, r_rk;
    logic                         r_oneg, r_pneg;

    logic [31:0] eij, ejk, eki;
    logic [19:0] ri, rk;
    logic        fi, fk;
    logic [33:0] t;
    logic        tneg;
    logic [32:0] tm;

    // Pick the corner's edges
    always_comb begin
        unique case (r_corner)
            2'd0: begin
                eij = r_len0; ejk = r_len1; eki = r_len2;
                ri = r_id0; rk = r_id2; fi = r_fl0; fk = r_fl2;
            end
            2'd1: begin
                eij = r_len1; ejk = r_len2; eki = r_len0;
                ri = r_id1; rk = r_id0; fi = r_fl1; fk = r_fl0;
            end
            default: begin
                eij = r_len2; ejk = r_len0; eki = r_len1;
                ri = r_id2; rk = r_id1; fi = r_fl2; fk = r_fl1;
            end
        endcase
        t    = {2'b00, eij} - {2'b00, ejk} + {2'b00, eki};
        tneg = t[33];
        tm   = tneg ? 33'(-t) : t[32:0];
    end

    assign o_face_ready = !r_busy;
    assign o_push       = r_busy && (r_phase == 2'd3) && !i_q_full;

    always_comb begin
        o_job.ri   = r_ri;
        o_job.rk   = r_rk;
        o_job.oneg = r_oneg;
        o_job.pneg = r_pneg;
        o_job.last = (r_corner == 2'd2);
        o_job.area = r_area;
        o_job.tm   = r_tm;
        o_job.tsq  = r_tsq;
        o_job.prod = r_prod;
        o_job.dden = {r_phi, 32'd0} + {32'd0, r_plo};
    end

    // Advance corner and phase
    always_comb begin
        n_busy   = r_busy;
        n_corner = r_corner;
        n_phase  = r_phase;
        if (!r_busy) begin
            if (i_face_valid) begin
                n_busy   = 1'b1;
                n_corner = 2'd0;
                n_phase  = 2'd0;
            end
        end else if (r_phase != 2'd3) begin
            n_phase = r_phase + 2'd1;
        end else if (!i_q_full) begin
            n_phase = 2'd0;
            if (r_corner == 2'd2) begin
                n_busy = 1'b0;
            end else begin
                n_corner = r_corner + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_corner <= 2'd0;
            r_phase  <= 2'd0;
        end else begin
            r_busy   <= n_busy;
            r_corner <= n_corner;
            r_phase  <= n_phase;
        end
    end

    // Hold the face and the products of the current corner
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_face_valid) begin
            r_len0 <= i_sq_len_0;
            r_len1 <= i_sq_len_1;
            r_len2 <= i_sq_len_2;
            r_area <= i_double_area;
            r_id0  <= i_edge_id_0;
            r_id1  <= i_edge_id_1;
            r_id2  <= i_edge_id_2;
            r_fl0  <= i_flip_0;
            r_fl1  <= i_flip_1;
            r_fl2  <= i_flip_2;
        end
        if (r_busy && r_phase == 2'd0) begin
            r_tm   <= tm;
            r_tsq  <= cr_vlf_pkg::TSQ_W'(tm) * cr_vlf_pkg::TSQ_W'(tm);
            r_prod <= {32'd0, eij} * {32'd0, eki};
            r_ri   <= ri;
            r_rk   <= rk;
            r_oneg <= fi ^ fk;
            r_pneg <= (tm == 33'd0) ? !(fi ^ fk) : !((fi ^ fk) ^ tneg);
        end
        if (r_busy && r_phase == 2'd1) begin
            r_plo <= {32'd0, r_prod[31:0]} * {32'd0, r_area};
        end
        if (r_busy && r_phase == 2'd2) begin
            r_phi <= {32'd0, r_prod[63:32]} * {32'd0, r_area};
        end
    end

endmodule

>>> design/cr_vlf_queue.sv
// Two-entry job queue between the front end and the back end.
module cr_vlf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cr_vlf_pkg::t_job  i_job,
    input  logic              i_pop,
    output cr_vlf_pkg::t_job  o_job,
    output logic              o_full,
    output logic              o_empty
);

    cr_vlf_pkg::t_job r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count out of range");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop) else $error("push into full queue");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("pop from empty queue");

endmodule

>>> design/cr_vlf_div.sv
// Bit-serial rounding divider with a 2^48 magnitude cap.
module cr_vlf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [cr_vlf_pkg::NUM_W-1:0]  i_num,
    input  logic [cr_vlf_pkg::DEN_W-1:0]  i_den,
    output logic                          o_done,
    output logic [cr_vlf_pkg::MAG_W-1:0]  o_mag
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_RUN  = 2'd1;
    localparam logic [1:0] D_FIN  = 2'd2;

    logic [1:0]                        r_state;
    logic [5:0]                        r_cnt;
    logic [cr_vlf_pkg::DEN_W-1:0]      r_rem;
    logic [cr_vlf_pkg::DEN_W-1:0]      r_den;
    logic [cr_vlf_pkg::QUO_W-1:0]      r_low;
    logic [cr_vlf_pkg::QUO_W-1:0]      r_quo;
    logic                              r_done;
    logic [cr_vlf_pkg::MAG_W-1:0]      r_mag;

    logic [56:0]                       num_hi;
    logic                              ovf;
    logic [cr_vlf_pkg::DEN_W:0]        trial;
    logic                              fits;
    logic [cr_vlf_pkg::QUO_W:0]        qr;

    always_comb begin
        num_hi = i_num[cr_vlf_pkg::NUM_W-1:cr_vlf_pkg::QUO_W];
        ovf    = {39'd0, num_hi} >= i_den;
        trial  = {r_rem, r_low[cr_vlf_pkg::QUO_W-1]};
        fits   = trial >= {1'b0, r_den};
        qr     = {1'b0, r_quo}
               + 50'({r_rem, 1'b0} >= {1'b0, r_den});
    end

    assign o_done = r_done;
    assign o_mag  = r_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        if (i_den == '0 || ovf) begin
                            r_done <= 1'b1;
                        end else begin
                            r_state <= D_RUN;
                        end
                    end
                end
                D_RUN: begin
                    if (r_cnt == 6'(cr_vlf_pkg::QUO_W - 1)) begin
                        r_state <= D_FIN;
                    end
                end
                D_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    // Shift one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (r_state == D_IDLE && i_start) begin
            r_rem <= {39'd0, num_hi};
            r_den <= i_den;
            r_low <= i_num[cr_vlf_pkg::QUO_W-1:0];
            r_quo <= '0;
            r_cnt <= '0;
            r_mag <= cr_vlf_pkg::MAG_CAP;
        end else if (r_state == D_RUN) begin
            r_rem <= fits ? cr_vlf_pkg::DEN_W'(trial - {1'b0, r_den})
                          : trial[cr_vlf_pkg::DEN_W-1:0];
            r_low <= {r_low[cr_vlf_pkg::QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[cr_vlf_pkg::QUO_W-2:0], fits};
            r_cnt <= r_cnt + 6'd1;
        end else if (r_state == D_FIN) begin
            r_mag <= (qr > {1'b0, cr_vlf_pkg::MAG_CAP}) ? cr_vlf_pkg::MAG_CAP
                                                         : qr[cr_vlf_pkg::MAG_W-1:0];
        end
    end

endmodule

>>> design/cr_vlf_back.sv
// Back end: runs the three divisions of a corner and emits its ten triplets.
module cr_vlf_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [20:0]                   i_edge_count,
    input  logic                          i_q_empty,
    input  cr_vlf_pkg::t_job              i_job,
    output logic                          o_pop,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [95:0]                   o_m_tdata,
    output logic                          o_m_tuser,
    output logic                          o_m_tlast
);

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_START = 2'd1;
    localparam logic [1:0] B_WAIT  = 2'd2;
    localparam logic [1:0] B_EMIT  = 2'd3;

    logic [1:0]                        r_state;
    logic [1:0]                        r_grp;
    logic [3:0]                        r_j;
    cr_vlf_pkg::t_job                  r_job;
    logic [cr_vlf_pkg::MAG_W-1:0]      r_mag;
    logic                              r_ovalid;
    logic [20:0]                       r_row, r_col;
    logic [47:0]                       r_val;
    logic                              r_sat, r_last;

    logic                              div_start, div_done;
    logic [cr_vlf_pkg::NUM_W-1:0]      div_num;
    logic [cr_vlf_pkg::DEN_W-1:0]      div_den;
    logic [cr_vlf_pkg::MAG_W-1:0]      div_mag;

    logic                              slot_free, emit, grp_end;
    logic                              row_k, row_n, col_k, col_n, neg;
    logic [20:0]                       row_base, col_base;
    logic [cr_vlf_pkg::MAG_W-1:0]      lim, v;
    logic                              sat;

    cr_vlf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_mag   (div_mag)
    );

    // Select the division of the current group
    always_comb begin
        div_start = (r_state == B_START);
        unique case (r_grp)
            2'd0: begin
                div_num = cr_vlf_pkg::NUM_W'(1) << 41;
                div_den = {64'd0, r_job.area};
            end
            2'd1: begin
                div_num = cr_vlf_pkg::NUM_W'({r_job.tsq, 39'd0});
                div_den = r_job.dden;
            end
            default: begin
                div_num = cr_vlf_pkg::NUM_W'({r_job.tm, 40'd0});
                div_den = {32'd0, r_job.prod};
            end
        endcase
    end

    // Decode the place of the triplet in the corner
    always_comb begin
        row_k = 1'b0; row_n = 1'b0; col_k = 1'b0; col_n = 1'b0; neg = 1'b0;
        unique case (r_j)
            4'd0: ;
            4'd1: begin row_n = 1'b1; col_n = 1'b1; end
            4'd2: begin col_k = 1'b1; neg = r_job.oneg; end
            4'd3: begin row_k = 1'b1; neg = r_job.oneg; end
            4'd4: begin row_n = 1'b1; col_k = 1'b1; col_n = 1'b1; neg = r_job.oneg; end
            4'd5: begin row_k = 1'b1; row_n = 1'b1; col_n = 1'b1; neg = r_job.oneg; end
            4'd6: begin col_k = 1'b1; col_n = 1'b1; neg = r_job.pneg; end
            4'd7: begin row_k = 1'b1; row_n = 1'b1; neg = r_job.pneg; end
            4'd8: begin row_n = 1'b1; col_k = 1'b1; neg = !r_job.pneg; end
            4'd9: begin row_k = 1'b1; col_n = 1'b1; neg = !r_job.pneg; end
            default: ;
        endcase
        row_base = {1'b0, row_k ? r_job.rk : r_job.ri};
        col_base = {1'b0, col_k ? r_job.rk : r_job.ri};
        lim      = neg ? 49'h0_8000_0000_0000 : 49'h0_7FFF_FFFF_FFFF;
        sat      = r_mag > lim;
        v        = sat ? lim : r_mag;
        grp_end  = (r_j == 4'd1) || (r_j == 4'd5) || (r_j == 4'd9);
    end

    assign slot_free = !r_ovalid || i_m_tready;
    assign emit      = (r_state == B_EMIT) && slot_free;
    assign o_pop     = (r_state == B_IDLE) && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_grp    <= 2'd0;
            r_j      <= 4'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_grp   <= 2'd0;
                        r_j     <= 4'd0;
                        r_state <= B_START;
                    end
                end
                B_START: r_state <= B_WAIT;
                B_WAIT: begin
                    if (div_done) begin
                        r_state <= B_EMIT;
                    end
                end
                B_EMIT: begin
                    if (slot_free) begin
                        r_j <= r_j + 4'd1;
                        if (grp_end) begin
                            if (r_j == 4'd9) begin
                                r_state <= B_IDLE;
                            end else begin
                                r_grp   <= r_grp + 2'd1;
                                r_state <= B_START;
                            end
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // Hold the job, the magnitude and the output transfer
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_state == B_WAIT && div_done) begin
            r_mag <= div_mag;
        end
        if (emit) begin
            r_row  <= row_base + (row_n ? i_edge_count : 21'd0);
            r_col  <= col_base + (col_n ? i_edge_count : 21'd0);
            r_val  <= neg ? 48'(-v[47:0]) : v[47:0];
            r_sat  <= sat;
            r_last <= r_job.last && (r_j == 4'd9);
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {6'd0, r_val, r_col, r_row};
    assign o_m_tuser  = r_sat;
    assign o_m_tlast  = r_last;

    a_j_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_EMIT |-> r_j <= 4'd9) else $error("triplet index out of range");
    a_grp_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_EMIT |-> (r_grp == 2'd0) == (r_j <= 4'd1))
        else $error("group and triplet index disagree");
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && r_j != 4'd9 |=> !r_last) else $error("last marked early");

endmodule
